[sv/clean_aperture_to_crop_assert.svh]
// Assertion macros used by the block's merge controller
`ifndef CLEAN_APERTURE_TO_CROP_ASSERT_SVH
`define CLEAN_APERTURE_TO_CROP_ASSERT_SVH

// Check that a condition implies a consequence on the same edge
`define CAC_ASSERT_IMPLY(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies a consequence on the next edge
`define CAC_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/cac_pkg.sv]
package cac_pkg;

  localparam int unsigned VALUE_WIDTH = 32;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_NEGATIVE = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] frame_width;
    logic [VALUE_WIDTH-1:0] frame_height;
    logic [VALUE_WIDTH-1:0] aperture_width_num;
    logic [VALUE_WIDTH-1:0] aperture_width_den;
    logic [VALUE_WIDTH-1:0] aperture_height_num;
    logic [VALUE_WIDTH-1:0] aperture_height_den;
    logic signed [VALUE_WIDTH-1:0] horiz_offset_num;
    logic [VALUE_WIDTH-1:0] horiz_offset_den;
    logic signed [VALUE_WIDTH-1:0] vert_offset_num;
    logic [VALUE_WIDTH-1:0] vert_offset_den;
  } req_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] top_num;
    logic [VALUE_WIDTH-1:0] top_den;
    logic [VALUE_WIDTH-1:0] bottom_num;
    logic [VALUE_WIDTH-1:0] bottom_den;
    logic [VALUE_WIDTH-1:0] left_num;
    logic [VALUE_WIDTH-1:0] left_den;
    logic [VALUE_WIDTH-1:0] right_num;
    logic [VALUE_WIDTH-1:0] right_den;
    status_t status;
  } rsp_t;

  // Per-axis lane input
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] frame;
    logic [VALUE_WIDTH-1:0] ap_num;
    logic [VALUE_WIDTH-1:0] ap_den;
    logic                   off_neg;
    logic [VALUE_WIDTH-1:0] off_mag;
    logic [VALUE_WIDTH-1:0] off_den;
  } lane_in_t;

  // Per-axis lane result
  typedef struct packed {
    status_t                status;
    logic [VALUE_WIDTH-1:0] p_num;
    logic [VALUE_WIDTH-1:0] p_den;
    logic [VALUE_WIDTH-1:0] m_num;
    logic [VALUE_WIDTH-1:0] m_den;
  } lane_out_t;

  // Lane handshake with the merge controller
  typedef struct packed {
    logic start;
  } lane_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_sts_t;

endpackage

[sv/cac_if.sv]
interface cac_req_if;
  logic valid;
  logic ready;
  cac_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface cac_rsp_if;
  logic valid;
  logic ready;
  cac_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[sv/clean_aperture_to_crop.sv]
// Each request runs the 64-bit bit-serial divider in each axis lane for gcd, lcm and
// reduction steps, so the time a request takes grows with the gcd steps its operands need.
// Throughput: one request at a time; the next is taken the cycle after the result is taken.
// Zero-denominator requests still wait until both lanes are idle.
// Reset: synchronous active-high rst clears all control state; no clearing pass.
module clean_aperture_to_crop (
  input  logic      clk,
  input  logic      rst,
  cac_req_if.sink   req,
  cac_rsp_if.source rsp
);

  cac_merge u_merge (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

endmodule

[sv/cac_divider.sv]
// Restoring divider, one quotient bit per cycle, 64-bit operands
module cac_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient,
  output logic [63:0] remainder
);

  logic [63:0] quo;
  logic [63:0] rem;
  logic [63:0] dvs;
  logic [6:0]  count;
  logic        active;
  logic [64:0] trial;
  logic [64:0] shifted;

  assign shifted = {rem, quo[63]};
  assign trial   = shifted - {1'b0, dvs};

  // Shift in one dividend bit and subtract when it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      count  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        count  <= 7'd64;
        quo    <= dividend;
        rem    <= '0;
        dvs    <= divisor;
      end else if (active) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= shifted[63:0];
          quo <= {quo[62:0], 1'b0};
        end
        count <= count - 7'd1;
        if (count == 7'd1) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

[sv/cac_lane.sv]
// One axis: lcm, products, two margins and their gcd reduction
module cac_lane (
  input  logic                clk,
  input  logic                rst,
  input  cac_pkg::lane_ctl_t  ctl,
  input  cac_pkg::lane_in_t   din,
  output cac_pkg::lane_sts_t  sts,
  output cac_pkg::lane_out_t  dout
);

  typedef enum logic [4:0] {
    S_IDLE, S_G1_DIV, S_G1_WAIT, S_L_DIV, S_L_WAIT, S_L_MUL,
    S_Q1_DIV, S_Q1_WAIT, S_Q2_DIV, S_Q2_WAIT, S_PROD, S_PROD_HI, S_SUMS,
    S_M_SETUP, S_M_DIV, S_M_WAIT, S_M_RED1, S_M_RED1_WAIT, S_M_RED2_WAIT,
    S_FINISH
  } state_t;

  state_t state;

  logic [63:0] ga;
  logic [63:0] gb;
  logic [63:0] lcm;
  logic [31:0] q_ap;
  logic [31:0] q_off;
  logic [63:0] prod_a;
  logic [63:0] prod_b;
  logic [63:0] prod_c;
  logic [64:0] pos_p;
  logic [64:0] neg_p;
  logic [64:0] pos_m;
  logic [64:0] neg_m;
  logic        side;
  logic [63:0] mnum;
  logic [63:0] mden;
  logic [63:0] mgcd;
  logic [63:0] red_num;
  logic        neg_flag;
  logic        ovf_flag;

  logic        div_start;
  logic [63:0] div_a;
  logic [63:0] div_b;
  logic        div_done;
  logic [63:0] div_q;
  logic [63:0] div_r;

  cac_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // 32x32 products; the 64-bit lcm times the frame takes two passes
  logic [63:0] mul_full;
  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [64:0] prod_sum;
  assign mul_full = mul_x * mul_y;
  assign prod_sum = {1'b0, prod_a} + {1'b0, mul_full[31:0], 32'd0};

  // Differences carry a sign bit above the 65-bit magnitude
  logic [65:0] diff;
  logic [65:0] diff_p;
  logic [65:0] diff_m;
  assign diff_p = {1'b0, pos_p} - {1'b0, neg_p};
  assign diff_m = {1'b0, pos_m} - {1'b0, neg_m};
  assign diff   = side ? diff_m : diff_p;

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (state)
      S_L_MUL: begin
        mul_x = q_ap;
        mul_y = 32'(din.off_den);
      end
      S_PROD: begin
        mul_x = lcm[31:0];
        mul_y = 32'(din.frame);
      end
      S_PROD_HI: begin
        mul_x = lcm[63:32];
        mul_y = 32'(din.frame);
      end
      S_SUMS: begin
        mul_x = q_ap;
        mul_y = 32'(din.ap_num);
      end
      S_M_SETUP: begin
        mul_x = q_off;
        mul_y = 32'(din.off_mag);
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  // Sequence the shared divider through gcd, lcm and reductions
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
      sts       <= '0;
    end else begin
      div_start <= 1'b0;
      sts.done  <= 1'b0;
      case (state)
        S_IDLE: begin
          if (ctl.start) begin
            sts.busy <= 1'b1;
            ga       <= 64'(din.ap_den);
            gb       <= 64'(din.off_den);
            ovf_flag <= 1'b0;
            neg_flag <= 1'b0;
            state    <= S_G1_DIV;
          end
        end
        S_G1_DIV: begin
          if (gb == '0) begin
            div_a     <= 64'(din.ap_den);
            div_b     <= ga;
            div_start <= 1'b1;
            state     <= S_L_WAIT;
          end else begin
            div_a     <= ga;
            div_b     <= gb;
            div_start <= 1'b1;
            state     <= S_G1_WAIT;
          end
        end
        S_G1_WAIT: begin
          if (div_done) begin
            ga    <= gb;
            gb    <= div_r;
            state <= S_G1_DIV;
          end
        end
        S_L_WAIT: begin
          if (div_done) begin
            q_ap  <= div_q[31:0];
            state <= S_L_MUL;
          end
        end
        S_L_MUL: begin
          lcm   <= mul_full;
          state <= S_L_DIV;
        end
        S_L_DIV: begin
          if (lcm[63]) begin
            ovf_flag <= 1'b1;
          end
          div_a     <= lcm;
          div_b     <= 64'(din.ap_den);
          div_start <= 1'b1;
          state     <= S_Q1_WAIT;
        end
        S_Q1_WAIT: begin
          if (div_done) begin
            q_ap      <= div_q[31:0];
            div_a     <= lcm;
            div_b     <= 64'(din.off_den);
            div_start <= 1'b1;
            state     <= S_Q2_WAIT;
          end
        end
        S_Q2_WAIT: begin
          if (div_done) begin
            q_off <= div_q[31:0];
            state <= S_PROD;
          end
        end
        S_PROD: begin
          prod_a <= mul_full;
          state  <= S_PROD_HI;
        end
        S_PROD_HI: begin
          // Add the upper partial product; any bit past 64 is an overflow
          prod_a <= prod_sum[63:0];
          if (mul_full[63:32] != '0 || prod_sum[64]) begin
            ovf_flag <= 1'b1;
          end
          state <= S_SUMS;
        end
        S_SUMS: begin
          prod_b <= mul_full;
          state  <= S_M_SETUP;
        end
        S_M_SETUP: begin
          // 2*|off|*q_off must fit 64 bits
          prod_c <= {mul_full[62:0], 1'b0};
          if (mul_full[63]) begin
            ovf_flag <= 1'b1;
          end
          state <= S_Q1_DIV;
        end
        S_Q1_DIV: begin
          // Form both margin sides: plus side gets c on pos unless offset negative
          if (!din.off_neg) begin
            pos_p <= {1'b0, prod_a} + {1'b0, prod_c};
            neg_p <= {1'b0, prod_b};
            pos_m <= {1'b0, prod_a};
            neg_m <= {1'b0, prod_b} + {1'b0, prod_c};
          end else begin
            pos_p <= {1'b0, prod_a};
            neg_p <= {1'b0, prod_b} + {1'b0, prod_c};
            pos_m <= {1'b0, prod_a} + {1'b0, prod_c};
            neg_m <= {1'b0, prod_b};
          end
          side  <= 1'b0;
          state <= (ovf_flag) ? S_FINISH : S_M_DIV;
        end
        S_M_DIV: begin
          // Check sign and magnitude, then start gcd of this side
          if (diff[65]) begin
            neg_flag <= 1'b1;
            state    <= S_M_RED2_WAIT;
          end else if (diff[64]) begin
            ovf_flag <= 1'b1;
            state    <= S_M_RED2_WAIT;
          end else begin
            mnum  <= diff[63:0];
            mden  <= {lcm[62:0], 1'b0};
            ga    <= diff[63:0];
            gb    <= {lcm[62:0], 1'b0};
            state <= S_M_WAIT;
          end
        end
        S_M_WAIT: begin
          if (gb == '0) begin
            mgcd      <= ga;
            div_a     <= mnum;
            div_b     <= ga;
            div_start <= 1'b1;
            state     <= S_M_RED1_WAIT;
          end else begin
            div_a     <= ga;
            div_b     <= gb;
            div_start <= 1'b1;
            state     <= S_M_RED1;
          end
        end
        S_M_RED1: begin
          if (div_done) begin
            ga    <= gb;
            gb    <= div_r;
            state <= S_M_WAIT;
          end
        end
        S_M_RED1_WAIT: begin
          if (div_done) begin
            red_num   <= div_q;
            div_a     <= mden;
            div_b     <= mgcd;
            div_start <= 1'b1;
            state     <= S_Q2_DIV;
          end
        end
        S_Q2_DIV: begin
          if (div_done) begin
            if (!side) begin
              dout.p_num <= red_num[cac_pkg::VALUE_WIDTH-1:0];
              dout.p_den <= div_q[cac_pkg::VALUE_WIDTH-1:0];
            end else begin
              dout.m_num <= red_num[cac_pkg::VALUE_WIDTH-1:0];
              dout.m_den <= div_q[cac_pkg::VALUE_WIDTH-1:0];
            end
            state <= S_M_RED2_WAIT;
          end
        end
        S_M_RED2_WAIT: begin
          if (side) begin
            state <= S_FINISH;
          end else begin
            side  <= 1'b1;
            state <= S_M_DIV;
          end
        end
        S_FINISH: begin
          dout.status <= ovf_flag ? cac_pkg::ST_OVERFLOW :
                         (neg_flag ? cac_pkg::ST_NEGATIVE : cac_pkg::ST_OK);
          sts.busy    <= 1'b0;
          sts.done    <= 1'b1;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/cac_merge.sv]
`include "clean_aperture_to_crop_assert.svh"

// Launch both lanes, combine their status and hold the result
module cac_merge (
  input  logic               clk,
  input  logic               rst,
  cac_req_if.sink            req,
  cac_rsp_if.source          rsp
);

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_OUT} mstate_t;

  mstate_t             state;
  cac_pkg::req_t       held;
  cac_pkg::lane_ctl_t  ctl;
  cac_pkg::lane_in_t   vin;
  cac_pkg::lane_in_t   hin;
  cac_pkg::lane_sts_t  vsts;
  cac_pkg::lane_sts_t  hsts;
  cac_pkg::lane_out_t  vout;
  cac_pkg::lane_out_t  hout;
  logic                vdone;
  logic                hdone;
  logic                zero_den;
  cac_pkg::status_t    st;

  assign vin.frame   = held.frame_height;
  assign vin.ap_num  = held.aperture_height_num;
  assign vin.ap_den  = held.aperture_height_den;
  assign vin.off_neg = held.vert_offset_num[cac_pkg::VALUE_WIDTH-1];
  assign vin.off_mag = held.vert_offset_num[cac_pkg::VALUE_WIDTH-1] ?
                       (~held.vert_offset_num + {{(cac_pkg::VALUE_WIDTH-1){1'b0}}, 1'b1}) :
                       held.vert_offset_num;
  assign vin.off_den = held.vert_offset_den;
  assign hin.frame   = held.frame_width;
  assign hin.ap_num  = held.aperture_width_num;
  assign hin.ap_den  = held.aperture_width_den;
  assign hin.off_neg = held.horiz_offset_num[cac_pkg::VALUE_WIDTH-1];
  assign hin.off_mag = held.horiz_offset_num[cac_pkg::VALUE_WIDTH-1] ?
                       (~held.horiz_offset_num + {{(cac_pkg::VALUE_WIDTH-1){1'b0}}, 1'b1}) :
                       held.horiz_offset_num;
  assign hin.off_den = held.horiz_offset_den;

  assign zero_den = (held.aperture_width_den == '0) || (held.aperture_height_den == '0) ||
                    (held.horiz_offset_den == '0) || (held.vert_offset_den == '0);

  cac_lane u_vert (.clk(clk), .rst(rst), .ctl(ctl), .din(vin), .sts(vsts), .dout(vout));
  cac_lane u_horiz (.clk(clk), .rst(rst), .ctl(ctl), .din(hin), .sts(hsts), .dout(hout));

  always_comb begin
    if (vout.status == cac_pkg::ST_OVERFLOW || hout.status == cac_pkg::ST_OVERFLOW) begin
      st = cac_pkg::ST_OVERFLOW;
    end else if (vout.status == cac_pkg::ST_NEGATIVE ||
                 hout.status == cac_pkg::ST_NEGATIVE) begin
      st = cac_pkg::ST_NEGATIVE;
    end else begin
      st = cac_pkg::ST_OK;
    end
  end

  assign req.ready = (state == M_IDLE);
  assign rsp.valid = (state == M_OUT);

  // Accept a request, run the lanes, hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      ctl   <= '0;
      vdone <= 1'b0;
      hdone <= 1'b0;
    end else begin
      ctl.start <= 1'b0;
      case (state)
        M_IDLE: begin
          if (req.valid) begin
            held  <= req.payload;
            vdone <= 1'b0;
            hdone <= 1'b0;
            state <= M_RUN;
            ctl.start <= 1'b1;
          end
        end
        M_RUN: begin
          if (zero_den && !ctl.start) begin
            rsp.payload <= '{status: cac_pkg::ST_ZERO_DEN, default: '0};
            if (!vsts.busy && !hsts.busy) begin
              state <= M_OUT;
            end
          end else begin
            if (vsts.done) vdone <= 1'b1;
            if (hsts.done) hdone <= 1'b1;
            if ((vdone || vsts.done) && (hdone || hsts.done) && !ctl.start) begin
              state <= M_OUT;
            end
          end
        end
        M_OUT: begin
          if (rsp.ready) begin
            state <= M_IDLE;
          end
        end
        default: begin
          state <= M_IDLE;
        end
      endcase
      if (state == M_RUN && !zero_den && (vdone || vsts.done) && (hdone || hsts.done)
          && !ctl.start) begin
        rsp.payload.status <= st;
        if (st == cac_pkg::ST_OK) begin
          rsp.payload.top_num    <= vout.p_num;
          rsp.payload.top_den    <= vout.p_den;
          rsp.payload.bottom_num <= vout.m_num;
          rsp.payload.bottom_den <= vout.m_den;
          rsp.payload.left_num   <= hout.p_num;
          rsp.payload.left_den   <= hout.p_den;
          rsp.payload.right_num  <= hout.m_num;
          rsp.payload.right_den  <= hout.m_den;
        end else begin
          rsp.payload.top_num    <= '0;
          rsp.payload.top_den    <= '0;
          rsp.payload.bottom_num <= '0;
          rsp.payload.bottom_den <= '0;
          rsp.payload.left_num   <= '0;
          rsp.payload.left_den   <= '0;
          rsp.payload.right_num  <= '0;
          rsp.payload.right_den  <= '0;
        end
      end
    end
  end

  `CAC_ASSERT_IMPLY(a_no_accept_busy, clk, rst, state != M_IDLE, !req.ready)
  `CAC_ASSERT_NEXT(a_start_runs, clk, rst, req.valid && req.ready, state == M_RUN)
  `CAC_ASSERT_NEXT(a_hold_out, clk, rst, rsp.valid && !rsp.ready, rsp.valid)
  `CAC_ASSERT_IMPLY(a_err_zero, clk, rst,
                    rsp.valid && rsp.payload.status != cac_pkg::ST_OK,
                    rsp.payload.top_num == '0 && rsp.payload.left_den == '0)

endmodule

[tb/crop_margin_checker.sv]
`timescale 1ns / 100ps

module crop_margin_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  cac_pkg::req_t req_payload,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  cac_pkg::rsp_t rsp_payload,
  output int            mismatches,
  output int            outstanding
);

  cac_pkg::rsp_t expected_margins[$];

  function automatic logic [63:0] gcd_u64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] t;
    while (b != 64'd0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Reduce pos - neg over den; negative and wide differences give a status
  function automatic cac_pkg::status_t reduce_margin(input logic [127:0] pos,
                                                     input logic [127:0] neg,
                                                     input logic [63:0] den,
                                                     output logic [63:0] num_r,
                                                     output logic [63:0] den_r);
    logic [127:0] diff;
    logic [63:0] g;
    num_r = 64'd0;
    den_r = 64'd0;
    if (pos < neg) return cac_pkg::ST_NEGATIVE;
    diff = pos - neg;
    if (diff[127:64] != 64'd0) return cac_pkg::ST_OVERFLOW;
    g = gcd_u64(diff[63:0], den);
    num_r = diff[63:0] / g;
    den_r = den / g;
    return cac_pkg::ST_OK;
  endfunction

  // Plus side (top/left) and minus side (bottom/right) margins of one axis
  function automatic cac_pkg::status_t axis_margins(input logic [31:0] frame,
                                                    input logic [31:0] ap_n,
                                                    input logic [31:0] ap_d,
                                                    input logic [31:0] off_raw,
                                                    input logic [31:0] off_d,
                                                    output logic [63:0] res [4]);
    logic [63:0] l, apd64, offd64;
    logic [127:0] den2, a, b, t, c;
    logic [31:0] mag;
    logic off_neg;
    cac_pkg::status_t s1, s2;
    for (int i = 0; i < 4; i++) res[i] = 64'd0;
    off_neg = off_raw[31];
    mag = off_neg ? (~off_raw + 32'd1) : off_raw;
    apd64 = {32'd0, ap_d};
    offd64 = {32'd0, off_d};
    l = (apd64 / gcd_u64(apd64, offd64)) * offd64;
    den2 = {64'd0, l} * 128'd2;
    if (den2[127:64] != 0) return cac_pkg::ST_OVERFLOW;
    a = {96'd0, frame} * {64'd0, l};
    if (a[127:64] != 0) return cac_pkg::ST_OVERFLOW;
    b = {96'd0, ap_n} * {64'd0, l / apd64};
    if (b[127:64] != 0) return cac_pkg::ST_OVERFLOW;
    t = {96'd0, mag} * {64'd0, l / offd64};
    if (t[127:64] != 0) return cac_pkg::ST_OVERFLOW;
    c = t * 128'd2;
    if (c[127:64] != 0) return cac_pkg::ST_OVERFLOW;
    if (!off_neg) begin
      s1 = reduce_margin(a + c, b, den2[63:0], res[0], res[1]);
      s2 = reduce_margin(a, b + c, den2[63:0], res[2], res[3]);
    end else begin
      s1 = reduce_margin(a, b + c, den2[63:0], res[0], res[1]);
      s2 = reduce_margin(a + c, b, den2[63:0], res[2], res[3]);
    end
    if (s1 == cac_pkg::ST_OVERFLOW || s2 == cac_pkg::ST_OVERFLOW) return cac_pkg::ST_OVERFLOW;
    if (s1 == cac_pkg::ST_NEGATIVE || s2 == cac_pkg::ST_NEGATIVE) return cac_pkg::ST_NEGATIVE;
    return cac_pkg::ST_OK;
  endfunction

  function automatic cac_pkg::rsp_t crop_margins(input cac_pkg::req_t r);
    cac_pkg::rsp_t m;
    logic [63:0] vert [4];
    logic [63:0] horiz [4];
    cac_pkg::status_t sv, sh, st;
    m = '0;
    if (r.aperture_width_den == 0 || r.aperture_height_den == 0 ||
        r.horiz_offset_den == 0 || r.vert_offset_den == 0) begin
      st = cac_pkg::ST_ZERO_DEN;
    end else begin
      sv = axis_margins(r.frame_height, r.aperture_height_num, r.aperture_height_den,
                        r.vert_offset_num, r.vert_offset_den, vert);
      sh = axis_margins(r.frame_width, r.aperture_width_num, r.aperture_width_den,
                        r.horiz_offset_num, r.horiz_offset_den, horiz);
      if (sv == cac_pkg::ST_OVERFLOW || sh == cac_pkg::ST_OVERFLOW) st = cac_pkg::ST_OVERFLOW;
      else if (sv == cac_pkg::ST_NEGATIVE || sh == cac_pkg::ST_NEGATIVE) begin
        st = cac_pkg::ST_NEGATIVE;
      end
      else st = cac_pkg::ST_OK;
    end
    if (st == cac_pkg::ST_OK) begin
      m.top_num = vert[0][31:0];
      m.top_den = vert[1][31:0];
      m.bottom_num = vert[2][31:0];
      m.bottom_den = vert[3][31:0];
      m.left_num = horiz[0][31:0];
      m.left_den = horiz[1][31:0];
      m.right_num = horiz[2][31:0];
      m.right_den = horiz[3][31:0];
    end
    m.status = st;
    return m;
  endfunction

  // Sample handshakes mid-cycle, where every signal is settled
  always @(negedge clk) begin
    cac_pkg::rsp_t exp_r;
    logic [31:0] ev [8];
    logic [31:0] av [8];
    bit bad;
    if (!rst) begin
      if (req_valid && req_ready) expected_margins.push_back(crop_margins(req_payload));
      if (rsp_valid && rsp_ready) begin
        if (expected_margins.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: %p", rsp_payload);
        end else begin
          exp_r = expected_margins.pop_front();
          ev = '{exp_r.top_num, exp_r.top_den, exp_r.bottom_num, exp_r.bottom_den,
                 exp_r.left_num, exp_r.left_den, exp_r.right_num, exp_r.right_den};
          av = '{rsp_payload.top_num, rsp_payload.top_den, rsp_payload.bottom_num,
                 rsp_payload.bottom_den, rsp_payload.left_num, rsp_payload.left_den,
                 rsp_payload.right_num, rsp_payload.right_den};
          bad = (exp_r.status !== rsp_payload.status);
          for (int i = 0; i < 8; i++) if (ev[i] !== av[i]) bad = 1'b1;
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("margin mismatch: expected %p", exp_r);
              $display("                 actual   %p", rsp_payload);
            end
          end
        end
      end
    end
    outstanding = expected_margins.size();
  end

endmodule

[tb/clean_aperture_to_crop_tb.sv]
`timescale 1ns / 100ps

module clean_aperture_to_crop_tb;

  localparam int CYCLE_LIMIT = 60_000_000;
  localparam int HOLD_CYCLES = 4000;
  localparam int RAND_PER_PHASE = 283;

  logic clk;
  logic rst;
  logic req_fire;
  int src_idle;
  int dst_idle;
  int hold_req;
  int hold_seen;
  int hold_left;
  int cycles;
  int sent;
  int mismatches;
  int outstanding;

  cac_req_if req_if ();
  cac_rsp_if rsp_if ();

  clean_aperture_to_crop i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source)
  );

  crop_margin_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_if.valid),
    .req_ready   (req_if.ready),
    .req_payload (req_if.payload),
    .rsp_valid   (rsp_if.valid),
    .rsp_ready   (rsp_if.ready),
    .rsp_payload (rsp_if.payload),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Request acceptance seen mid-cycle, read at the following edge
  always @(negedge clk) req_fire = req_if.valid && req_if.ready && !rst;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    rsp_if.ready <= 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= dst_idle);
      end
    end
  end

  function automatic cac_pkg::req_t make_req(input logic [31:0] fw, input logic [31:0] fh,
                                             input logic [31:0] awn, input logic [31:0] awd,
                                             input logic [31:0] ahn, input logic [31:0] ahd,
                                             input logic [31:0] hn, input logic [31:0] hd,
                                             input logic [31:0] vn, input logic [31:0] vd);
    cac_pkg::req_t r;
    r.frame_width = fw;
    r.frame_height = fh;
    r.aperture_width_num = awn;
    r.aperture_width_den = awd;
    r.aperture_height_num = ahn;
    r.aperture_height_den = ahd;
    r.horiz_offset_num = hn;
    r.horiz_offset_den = hd;
    r.vert_offset_num = vn;
    r.vert_offset_den = vd;
    return r;
  endfunction

  // Mostly sane apertures inside the frame; some noise, zero and huge values
  function automatic cac_pkg::req_t rand_req();
    cac_pkg::req_t r;
    logic [31:0] f [2];
    logic [31:0] n [2];
    logic [31:0] d [2];
    logic [31:0] on [2];
    logic [31:0] od [2];
    int mode;
    int spread;
    mode = $urandom_range(19);
    if (mode < 2) begin
      r = {$urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom};
      return r;
    end
    for (int i = 0; i < 2; i++) begin
      f[i] = (mode == 2) ? $urandom : $urandom_range(0, 4096);
      d[i] = $urandom_range(1, 12);
      od[i] = $urandom_range(1, 12);
      n[i] = $urandom_range(0, f[i] % 100000) * d[i] + $urandom_range(0, d[i] - 1);
      spread = (f[i] % 4096) * od[i] / 8 + 1;
      on[i] = (mode == 3) ? $urandom : 32'($signed($urandom_range(0, 2 * spread)) - spread);
    end
    r = make_req(f[0], f[1], n[0], d[0], n[1], d[1], on[0], od[0], on[1], od[1]);
    if (mode == 4) begin
      case ($urandom_range(3))
        0: r.aperture_width_den = '0;
        1: r.aperture_height_den = '0;
        2: r.horiz_offset_den = '0;
        default: r.vert_offset_den = '0;
      endcase
    end
    if (mode == 5) begin
      r.aperture_width_den = $urandom;
      r.horiz_offset_den = $urandom;
    end
    return r;
  endfunction

  task automatic send_req(input cac_pkg::req_t r);
    while ($urandom_range(99) < src_idle) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.payload <= r;
    @(posedge clk);
    while (!req_fire) @(posedge clk);
    sent++;
  endtask

  // Hold back new requests until every result is back
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    @(posedge clk);
  endtask

  initial begin
    cac_pkg::req_t directed [$];
    rst <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.payload <= '0;
    src_idle = 26;
    dst_idle = 71;
    hold_req = 0;
    sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, each zero denominator, sign extremes, status cases
    directed.push_back(make_req(0, 0, 0, 1, 0, 1, 0, 1, 0, 1));
    directed.push_back(make_req(1920, 1080, 1920, 1, 1080, 1, 0, 1, 0, 1));
    directed.push_back(make_req(1920, 1080, 1800, 1, 1000, 1, 10, 1, -20, 1));
    directed.push_back(make_req(720, 480, 1403, 2, 959, 2, -7, 3, 5, 7));
    directed.push_back(make_req(100, 100, 10, 0, 10, 1, 0, 1, 0, 1));
    directed.push_back(make_req(100, 100, 10, 1, 10, 0, 0, 1, 0, 1));
    directed.push_back(make_req(100, 100, 10, 1, 10, 1, 0, 0, 0, 1));
    directed.push_back(make_req(100, 100, 10, 1, 10, 1, 0, 1, 0, 0));
    directed.push_back(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_req(100, 100, 200, 1, 50, 1, 0, 1, 0, 1));
    directed.push_back(make_req(100, 100, 50, 1, 50, 1, 100, 1, 0, 1));
    directed.push_back(make_req(100, 100, 50, 1, 50, 1, 0, 1, 32'h8000_0000, 1));
    directed.push_back(make_req(100, 100, 50, 1, 50, 1, 32'h7fff_ffff, 1, 0, 1));
    directed.push_back(make_req('1, '1, '1, '1, '1, '1, 32'h7fff_ffff, '1,
                                32'h8000_0000, '1));
    directed.push_back(make_req('1, '1, 0, 1, 0, 1, 0, 1, 0, 1));
    directed.push_back(make_req('1, 100, 0, 32'hffff_fffb, 50, 1, 0, 32'hffff_fff1, 0, 1));
    directed.push_back(make_req(100, 100, 0, 1, 0, 1, '1, '1, '1, '1));
    directed.push_back(make_req(100, 100, 300, 3, 300, 3, 0, 5, 0, 7));
    directed.push_back(make_req(4096, 4096, 4096, 1, 4095, 1, 1, 2, -1, 2));
    foreach (directed[i]) send_req(directed[i]);

    for (int ph = 0; ph < 3; ph++) begin
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        if (ph == 0 && k == 40) hold_req++;
        send_req(rand_req());
      end
      drain_results();
      src_idle = (ph == 0) ? 71 : 0;
      dst_idle = (ph == 0) ? 26 : 0;
    end

    wait (outstanding == 0);
    repeat (1500) @(posedge clk);
    $display("Ran %0d crop requests over three idle mixes, with a long result hold-off", sent);
    $display("and full drains between mixes; zero, overflow and negative cases included.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
